// ===== src/assert_macros.svh =====
// Assertion helpers; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;
	localparam int VOICES = 16;
	localparam int VW = $clog2(VOICES);
	localparam int SAMPLE_WORDS = 65536;
	localparam int SAW = $clog2(SAMPLE_WORDS);
	localparam int ACCW = 37;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0, OP_PLAY = 3'd1, OP_PAUSE = 3'd2, OP_STOP = 3'd3,
		OP_GPAUSE = 3'd4, OP_GSTOP = 3'd5, OP_TICK = 3'd6, OP_NONE = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_READ, S_MIX, S_TICKEND, S_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] base;
		logic [16:0] len;
		logic [16:0] cursor;
		logic [7:0] group;
		logic [15:0] gain;
		logic loop;
		logic paused;
	} voice_t;

	localparam int VOICE_BITS = $bits(voice_t);
endpackage
`default_nettype wire

// ===== src/svm_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface svm_in_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic [15:0] sample_address;
	logic [16:0] length;
	logic signed [15:0] sample_value;
	logic [15:0] voice_id;
	logic [7:0] group_mask;
	logic [15:0] volume;
	logic flag;
	modport source(output valid, operation, sample_address, length, sample_value, voice_id,
		group_mask, volume, flag, input ready);
	modport sink(input valid, operation, sample_address, length, sample_value, voice_id,
		group_mask, volume, flag, output ready);
endinterface

interface svm_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [15:0] assigned_id;
	logic signed [15:0] mix_sample;
	modport source(output valid, status, assigned_id, mix_sample, input ready);
	modport sink(input valid, status, assigned_id, mix_sample, output ready);
endinterface
`default_nettype wire

// ===== src/svm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module svm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/sample_voice_mixer.sv =====
// A tick walks every voice through S_READ, S_MIX and S_TICKEND and then posts its
// result from S_OUT; every other request passes through S_SCAN to S_OUT and posts it there.
// One request at a time: the next request is taken only once the previous one has left
// S_OUT for S_IDLE. A result stalled in the output register keeps the request that follows
// it waiting in S_OUT, and so holds back the next request as well.
// Reset clears the valid and paused bits, the id counter, paused groups and the ignore
// mask at once; the sample and voice memories keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sample_voice_mixer
	import svm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	svm_in_if.sink in_ch,
	svm_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata
);
	// Control and small state in flops; voice records and samples in RAM.
	state_t state_q, state_d;
	logic [7:0] ignored_q, pgroups_q;
	logic [15:0] last_id_q;
	logic [VOICES-1:0] valid_q, paused_q;
	logic [VOICES-1:0][7:0] group_q;
	logic [VOICES-1:0][15:0] tag_q;
	logic [VW-1:0] idx_q;
	logic [2:0] op_q;
	logic [15:0] addr_q, vid_q, gain_q;
	logic [16:0] len_q;
	logic [15:0] sval_q;
	logic [7:0] gmask_q;
	logic flag_q;
	logic [ACCW-1:0] acc_q;
	voice_t vrec_s1;
	// Working result of the request in progress, moved to the output register at the end.
	logic [1:0] res_status_q;
	logic [15:0] res_aid_q;
	logic [1:0] status_q;
	logic [15:0] aid_q;
	logic [15:0] mix_q;
	logic out_valid_q;

	// Voice RAM ports.
	logic vwe;
	logic [VW-1:0] vwaddr, vraddr;
	voice_t vwdata, vrdata;
	svm_ram #(.WIDTH(VOICE_BITS), .DEPTH(VOICES)) u_voice_ram (
		.clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
		.raddr(vraddr), .rdata(vrdata)
	);

	// Sample RAM: written by sample writes, read by the tick.
	logic swe;
	logic [SAW-1:0] sraddr;
	logic [15:0] srdata;
	svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
		.clk(clk), .we(swe), .waddr(addr_q[SAW-1:0]), .wdata(sval_q),
		.raddr(sraddr), .rdata(srdata)
	);

	logic idx_last;
	assign idx_last = (idx_q == VW'(VOICES - 1));
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.status = status_q;
	assign out_ch.assigned_id = aid_q;
	assign out_ch.mix_sample = mix_q;

	// Lowest free slot and lowest id match, found in the cycle after accept.
	logic free_any, hit_any;
	logic [VW-1:0] free_idx, hit_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		hit_any = 1'b0;
		hit_idx = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!valid_q[v]) begin
				free_any = 1'b1;
				free_idx = VW'(v);
			end
			if (valid_q[v] && tag_q[v] == vid_q && vid_q != 16'd0) begin
				hit_any = 1'b1;
				hit_idx = VW'(v);
			end
		end
	end

	// The voice being mixed: is it running, and what is its next cursor.
	logic running, has_frame;
	logic [16:0] cur_inc, cur_new;
	always_comb begin
		running = valid_q[idx_q] && !paused_q[idx_q] && ((pgroups_q & group_q[idx_q]) == 8'd0);
		has_frame = vrec_s1.cursor < vrec_s1.len;
		cur_inc = has_frame ? vrec_s1.cursor + 17'd1 : vrec_s1.cursor;
		cur_new = (vrec_s1.loop && cur_inc == vrec_s1.len) ? 17'd0 : cur_inc;
		if (!running) begin
			cur_new = vrec_s1.cursor;
		end
	end

	logic [15:0] next_id;
	assign next_id = (last_id_q == 16'hFFFF) ? 16'd1 : last_id_q + 16'd1;

	// Product of the sample read and the gain, registered before accumulation.
	logic signed [32:0] prod_s2;
	logic prod_en_s2;

	// Rounding and saturation of the mixed frame.
	logic [ACCW-1:0] rnd;
	logic signed [ACCW-16:0] shr;
	logic [15:0] sat;
	always_comb begin
		rnd = acc_q + ACCW'(16384);
		shr = $signed(rnd[ACCW-1:15]);
		if (shr > $signed((ACCW-15)'(32767))) begin
			sat = 16'h7FFF;
		end else if (shr < -$signed((ACCW-15)'(32768))) begin
			sat = 16'h8000;
		end else begin
			sat = shr[15:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_ch.valid) state_d = (in_ch.operation == OP_TICK) ? S_READ
				: S_SCAN;
			S_SCAN: state_d = S_OUT;
			S_READ: state_d = S_MIX;
			S_MIX: state_d = S_TICKEND;
			S_TICKEND: state_d = idx_last ? S_OUT : S_READ;
			S_OUT: if (!out_valid_q || out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// The voice record must be on the read port while the voice is in S_READ, so the
	// address runs one step ahead: voice zero while idle, the next voice at the end of one.
	always_comb begin
		if (state_q == S_IDLE) begin
			vraddr = '0;
		end else if (state_q == S_TICKEND) begin
			vraddr = idx_q + VW'(1);
		end else begin
			vraddr = idx_q;
		end
		vwe = 1'b0;
		vwaddr = idx_q;
		vwdata = vrec_s1;
		vwdata.cursor = cur_new;
		swe = (state_q == S_SCAN) && (op_q == OP_WRITE);
		sraddr = SAW'(vrdata.base + 16'(vrdata.cursor));
		if (state_q == S_SCAN && op_q == OP_PLAY) begin
			vwe = ((ignored_q & gmask_q) == 8'd0) && free_any;
			vwaddr = free_idx;
			vwdata.tag = next_id;
			vwdata.base = addr_q;
			vwdata.len = len_q;
			vwdata.cursor = 17'd0;
			vwdata.group = gmask_q;
			vwdata.gain = gain_q;
			vwdata.loop = flag_q;
			vwdata.paused = 1'b0;
		end else if (state_q == S_TICKEND) begin
			vwe = running;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ignored_q <= '0;
			pgroups_q <= '0;
			last_id_q <= '0;
			valid_q <= '0;
			paused_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			acc_q <= '0;
			res_status_q <= ST_OK;
			res_aid_q <= '0;
			status_q <= ST_OK;
			aid_q <= '0;
			mix_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ignored_q <= cfg_wdata;
			end
			// The output register takes a new result once the previous one has left.
			if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
				status_q <= res_status_q;
				aid_q <= res_aid_q;
				mix_q <= (op_q == OP_TICK) ? sat : 16'd0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					acc_q <= '0;
					res_status_q <= ST_OK;
					res_aid_q <= '0;
				end
				S_SCAN: begin
					case (op_q)
						OP_PLAY: begin
							if ((ignored_q & gmask_q) != 8'd0) begin
								res_status_q <= ST_IGNORED;
							end else if (!free_any) begin
								res_status_q <= ST_FULL;
							end else begin
								last_id_q <= next_id;
								res_aid_q <= next_id;
								valid_q[free_idx] <= 1'b1;
								paused_q[free_idx] <= 1'b0;
							end
						end
						OP_PAUSE: if (hit_any) paused_q[hit_idx] <= flag_q;
						OP_STOP: if (hit_any) valid_q[hit_idx] <= 1'b0;
						OP_GPAUSE: pgroups_q <= flag_q ? (pgroups_q | gmask_q)
							: (pgroups_q & ~gmask_q);
						OP_GSTOP: begin
							for (int v = 0; v < VOICES; v++) begin
								if ((group_q[v] & gmask_q) != 8'd0) valid_q[v] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				S_TICKEND: begin
					if (valid_q[idx_q] && cur_new >= vrec_s1.len) begin
						valid_q[idx_q] <= 1'b0;
					end
					if (prod_en_s2) begin
						acc_q <= acc_q + ACCW'(prod_s2);
					end
					if (!idx_last) begin
						idx_q <= idx_q + VW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers, the tag and group copies, and the tick's voice and product registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			op_q <= in_ch.operation;
			addr_q <= in_ch.sample_address;
			len_q <= in_ch.length;
			sval_q <= in_ch.sample_value;
			vid_q <= in_ch.voice_id;
			gmask_q <= in_ch.group_mask;
			gain_q <= in_ch.volume;
			flag_q <= in_ch.flag;
		end
		if (vwe && state_q == S_SCAN) begin
			tag_q[vwaddr] <= next_id;
			group_q[vwaddr] <= gmask_q;
		end
		if (state_q == S_READ) begin
			vrec_s1 <= vrdata;
		end
		if (state_q == S_MIX) begin
			prod_s2 <= $signed(srdata) * $signed({1'b0, vrec_s1.gain});
			prod_en_s2 <= running && has_frame;
		end
	end

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid_q && !out_ch.ready |=> out_valid_q && $stable(mix_q), "result dropped while stalled")
	`ASSERT_NEVER(a_busy_ready, clk, arst_n, in_ch.ready && out_valid_q && state_q != S_IDLE, "ready outside idle")
	`ASSERT_CLK(a_id_nonzero, clk, arst_n, state_q == S_SCAN && vwe |=> last_id_q != 16'd0, "id zero assigned")
endmodule
`default_nettype wire
